// File: design/sudm_pkg.sv
// Shared types, constants and codes for the scaled utility dot product block.
// Used by the lane, merge and top-level modules; depends on nothing else.
`default_nettype none

package sudm_pkg;

    // Dimensions carried by one data point and dimensions actually evaluated.
    localparam int NUM_DIMS  = 4;
    localparam int DIMENSION = 4;
    localparam int DIM_IDX_W = $clog2(NUM_DIMS);

    // Field widths.
    localparam int COORD_W = 16;
    localparam int ATTR_W  = 16;
    localparam int TERM_W  = 32;
    localparam int UTIL_W  = 35;
    localparam int MAX_W   = 34;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register index codes: weights first, then attribute maxima.
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_BASE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ATTR_BASE   = CFG_IDX_W'(NUM_DIMS);

    // 1.0 in unsigned Q8.8.
    localparam logic [ATTR_W-1:0] ONE_Q8_8 = ATTR_W'(256);

    // Divider geometry. The scaled term is (|product| << 8) / max with max above 1.0,
    // so the quotient always fits in the low QUO_W bits of the dividend.
    localparam int PROD_W      = 2 * COORD_W;
    localparam int MAG_W       = PROD_W - 1;
    localparam int FRAC_SHIFT  = 8;
    localparam int DIVIDEND_W  = MAG_W + FRAC_SHIFT;
    localparam int QUO_W       = 32;
    localparam int REM_W       = ATTR_W;
    localparam int DIV_BITS    = 4;
    localparam int DIV_STEPS   = QUO_W / DIV_BITS;
    localparam int DIV_STEP_W  = $clog2(DIV_STEPS);

    typedef logic signed [COORD_W-1:0] t_q412;
    typedef logic        [ATTR_W-1:0]  t_q88;
    typedef logic signed [TERM_W-1:0]  t_term;
    typedef logic signed [UTIL_W-1:0]  t_util;
    typedef logic        [MAX_W-1:0]   t_max;

    // One input item.
    typedef struct packed {
        logic signed [COORD_W-1:0] coord_0;
        logic signed [COORD_W-1:0] coord_1;
        logic signed [COORD_W-1:0] coord_2;
        logic signed [COORD_W-1:0] coord_3;
        logic                      start_of_set;
    } t_in;

    // One result item.
    typedef struct packed {
        logic signed [UTIL_W-1:0] utility;
        logic        [MAX_W-1:0]  set_max;
    } t_out;

    // Control from the sequencer to every lane.
    typedef struct packed {
        logic load;
        logic prep;
        logic step;
        logic term;
    } t_lane_ctl;

    // Control from the sequencer to the merge stage.
    typedef struct packed {
        logic sum_en;
        logic out_en;
        logic start_of_set;
    } t_merge_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_TERM,
        S_SUM,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// File: design/sudm_lane.sv
// One dimension lane: coordinate times weight, then an iterative divide by the
// attribute maximum above 1.0 (four quotient bits per cycle). Uses sudm_pkg.
`default_nettype none

module sudm_lane (
    input  wire                 i_clk,
    input  sudm_pkg::t_lane_ctl i_ctl,
    input  sudm_pkg::t_q412     i_coord,
    input  sudm_pkg::t_q412     i_weight,
    input  sudm_pkg::t_q88      i_attr_max,
    output sudm_pkg::t_term     o_term
);
    import sudm_pkg::*;

    t_term             r_prod;
    logic              r_neg;
    logic              r_bypass;
    logic [REM_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_quo;
    t_term             r_term;

    logic [MAG_W-1:0]      w_mag;
    logic [DIVIDEND_W-1:0] w_dividend;
    logic [REM_W-1:0]      n_rem;
    logic [QUO_W-1:0]      n_quo;
    t_term                 w_quo_signed;

    // Magnitude of the product, scaled up by 256 to form the dividend.
    always_comb begin
        w_mag      = r_prod[PROD_W-1] ? MAG_W'(-r_prod) : MAG_W'(r_prod);
        w_dividend = {w_mag, {FRAC_SHIFT{1'b0}}};
    end

    // Restoring division, DIV_BITS quotient bits per cycle. The quotient bits
    // shift in at the bottom as the dividend bits shift out at the top.
    always_comb begin
        logic [REM_W:0] trial;
        n_rem = r_rem;
        n_quo = r_quo;
        trial = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial = {n_rem, n_quo[QUO_W-1]};
            n_quo = {n_quo[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, i_attr_max}) begin
                trial    = trial - {1'b0, i_attr_max};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[REM_W-1:0];
        end
    end

    // Quotient with the product's sign restored; truncation is toward zero.
    assign w_quo_signed = r_neg ? -$signed(r_quo) : $signed(r_quo);

    // Datapath registers, advanced by the sequencer.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_prod <= i_coord * i_weight;
        end
        if (i_ctl.prep) begin
            r_neg    <= r_prod[PROD_W-1];
            r_bypass <= (i_attr_max <= ONE_Q8_8);
            r_rem    <= REM_W'(w_dividend[DIVIDEND_W-1:QUO_W]);
            r_quo    <= w_dividend[QUO_W-1:0];
        end else if (i_ctl.step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
        if (i_ctl.term) begin
            r_term <= r_bypass ? r_prod : w_quo_signed;
        end
    end

    assign o_term = r_term;

endmodule

`default_nettype wire

// File: design/sudm_merge.sv
// Merge stage: sums the lane terms, updates the running set maximum and holds
// the result register on the output channel. Depends on sudm_pkg.
`default_nettype none

module sudm_merge (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  sudm_pkg::t_merge_ctl                   i_ctl,
    input  sudm_pkg::t_term [sudm_pkg::DIMENSION-1:0] i_terms,
    input  wire                                    i_out_stall,
    output logic                                   o_out_valid,
    output sudm_pkg::t_out                         o_out_data,
    output logic                                   o_slot_free
);
    import sudm_pkg::*;

    t_util r_sum;
    t_max  r_max;
    logic  r_out_valid;
    t_out  r_out_data;

    t_util n_sum;
    t_max  w_base;
    t_max  n_max;

    // Sign-extended sum of all lane terms.
    always_comb begin
        n_sum = '0;
        for (int d = 0; d < DIMENSION; d++) begin
            n_sum = n_sum + {{(UTIL_W-TERM_W){i_terms[d][TERM_W-1]}}, i_terms[d]};
        end
    end

    // The maximum restarts at zero on a new set and moves only on a strictly larger sum.
    always_comb begin
        w_base = i_ctl.start_of_set ? '0 : r_max;
        if (r_sum > $signed({1'b0, w_base})) begin
            n_max = r_sum[MAX_W-1:0];
        end else begin
            n_max = w_base;
        end
    end

    assign o_slot_free = !r_out_valid || !i_out_stall;

    // Sum register and result payload.
    always_ff @(posedge i_clk) begin
        if (i_ctl.sum_en) begin
            r_sum <= n_sum;
        end
        if (i_ctl.out_en) begin
            r_out_data.utility <= r_sum;
            r_out_data.set_max <= n_max;
        end
    end

    // Running maximum and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.out_en) begin
                r_max       <= n_max;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// File: design/scaled_utility_dot_max_top.sv
// An item's transfer starts the multiply; setup, the lane divide steps at 4 quotient
// bits per cycle, term, sum and output follow in that order. No new item is taken
// until the block is back in its idle step. A previous result still stalled on the
// output holds the block in its output step until that transfer completes.
// Reset (synchronous, active low) clears weights to 0, maxima to 1.0, the running
// maximum to 0 and empties both channels. Depends on sudm_pkg, sudm_lane, sudm_merge.
`default_nettype none

module scaled_utility_dot_max_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    input  sudm_pkg::t_in                       i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output sudm_pkg::t_out                      o_out_data,
    input  wire                                 i_out_stall,
    input  wire                                 i_cfg_we,
    input  wire [sudm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [sudm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import sudm_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [DIV_STEP_W-1:0] r_step;
    logic                  r_sos;
    t_q412                 r_weight   [NUM_DIMS];
    t_q88                  r_attr_max [NUM_DIMS];

    t_lane_ctl               w_lane_ctl;
    t_merge_ctl              w_merge_ctl;
    logic                    w_accept;
    logic                    w_slot_free;
    t_q412                   w_coord [NUM_DIMS];
    t_term [DIMENSION-1:0]   w_terms;

    localparam logic [DIV_STEP_W-1:0] LAST_STEP = DIV_STEP_W'(DIV_STEPS - 1);

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_coord[0] = i_in_data.coord_0;
    assign w_coord[1] = i_in_data.coord_1;
    assign w_coord[2] = i_in_data.coord_2;
    assign w_coord[3] = i_in_data.coord_3;

    // Configuration registers; the index width covers exactly the weights and the maxima.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < NUM_DIMS; d++) begin
                r_weight[d]   <= '0;
                r_attr_max[d] <= ONE_Q8_8;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index < CFG_ATTR_BASE) begin
                r_weight[i_cfg_index[DIM_IDX_W-1:0]] <= t_q412'(i_cfg_data);
            end else begin
                r_attr_max[i_cfg_index[DIM_IDX_W-1:0]] <= t_q88'(i_cfg_data);
            end
        end
    end

    // Sequencer state and divide step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PREP) begin
                r_step <= '0;
            end else if (r_state == S_DIV) begin
                r_step <= r_step + DIV_STEP_W'(1);
            end
        end
    end

    // The start-of-set flag travels with the item to the merge stage.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sos <= i_in_data.start_of_set;
        end
    end

    // Next state and control for lanes and merge.
    always_comb begin
        n_state     = r_state;
        w_lane_ctl  = '0;
        w_merge_ctl = '0;
        w_merge_ctl.start_of_set = r_sos;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_lane_ctl.load = 1'b1;
                    n_state         = S_PREP;
                end
            end
            S_PREP: begin
                w_lane_ctl.prep = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                w_lane_ctl.step = 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_TERM;
                end
            end
            S_TERM: begin
                w_lane_ctl.term = 1'b1;
                n_state         = S_SUM;
            end
            S_SUM: begin
                w_merge_ctl.sum_en = 1'b1;
                n_state            = S_OUT;
            end
            S_OUT: begin
                if (w_slot_free) begin
                    w_merge_ctl.out_en = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // One lane per evaluated dimension.
    for (genvar d = 0; d < DIMENSION; d++) begin : g_lane
        sudm_lane u_lane (
            .i_clk      (i_clk),
            .i_ctl      (w_lane_ctl),
            .i_coord    (w_coord[d]),
            .i_weight   (r_weight[d]),
            .i_attr_max (r_attr_max[d]),
            .o_term     (w_terms[d])
        );
    end

    sudm_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_merge_ctl),
        .i_terms     (w_terms),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_slot_free (w_slot_free)
    );

endmodule

`default_nettype wire
